@@ rtl/rlws_pkg.sv @@
// Package for the radio listen window scheduler: widths, codes, phase type
// and the shared timeout helper. No dependencies.
package rlws_pkg;

  localparam int MaxBands  = 4;
  localparam int BandW     = $clog2(MaxBands);
  localparam int BandCntW  = 3;
  localparam int CmdW      = 3;
  localparam int TimeW     = 63;
  localparam int LimitW    = 40;
  localparam int CountW    = 16;
  localparam int DataW     = 64;
  localparam int AddrW     = 6;
  localparam int RegIdxW   = 3;

  localparam logic [LimitW-1:0]   AcqTimeoutRst = 40'd600000000;
  localparam logic [LimitW-1:0]   BandDwellRst  = 40'd60000000;
  localparam logic [LimitW-1:0]   IntervalRst   = 40'd3600000000;
  localparam logic [LimitW-1:0]   DurationRst   = 40'd300000000;
  localparam logic [BandCntW-1:0] BandCountRst  = 3'd3;
  localparam logic [BandCntW-1:0] BandCountMax  = BandCntW'(MaxBands);
  localparam logic [CountW-1:0]   CountMax      = '1;

  typedef enum logic [CmdW-1:0] {
    CmdTick      = 3'd0,
    CmdRadioFix  = 3'd1,
    CmdBcastFix  = 3'd2,
    CmdReqListen = 3'd3,
    CmdReqServe  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    PhAcq = 2'd0,
    PhSrv = 2'd1,
    PhLis = 2'd2
  } phase_e;

  typedef enum logic [RegIdxW-1:0] {
    RegAcqTimeout = 3'd0,
    RegBandDwell  = 3'd1,
    RegInterval   = 3'd2,
    RegDuration   = 3'd3,
    RegExitOnFix  = 3'd4,
    RegBandCount  = 3'd5
  } reg_e;

  function automatic logic elapsed(input logic [TimeW-1:0] now,
                                   input logic [TimeW-1:0] start,
                                   input logic [LimitW-1:0] limit);
    logic [TimeW:0] diff;
    diff = {1'b0, now} - {1'b0, start};
    return !diff[TimeW] && (diff[TimeW-1:0] >= {{(TimeW-LimitW){1'b0}}, limit});
  endfunction

endpackage

@@ rtl/rlws_if.sv @@
// Channel interfaces for the scheduler: event items in, directive items out.
// Depends on rlws_pkg for field widths.
interface rlws_evt_if;
  import rlws_pkg::*;
  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     command;
  logic [TimeW-1:0]    time_us;

  modport source (output valid, output command, output time_us, input ready);
  modport sink   (input valid, input command, input time_us, output ready);
endinterface

interface rlws_dir_if;
  import rlws_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        phase;
  logic              link_up;
  logic              radio_listening;
  logic [BandW-1:0]  band_index;
  logic              band_valid;

  modport source (output valid, output phase, output link_up, output radio_listening,
                  output band_index, output band_valid, input ready);
  modport sink   (input valid, input phase, input link_up, input radio_listening,
                  input band_index, input band_valid, output ready);
endinterface

@@ rtl/radio_listen_window_scheduler.sv @@
// Top level of the radio listen window scheduler: event register, phase and
// band logic, directive register and APB register file.
// Depends on rlws_pkg and the channel interfaces in rlws_if.sv.
//
//   channel  | dir | handshake     | payload
//   evt_i    | in  | valid/ready   | command, time_us
//   dir_o    | out | valid/ready   | phase, link_up, radio_listening, band_index, band_valid
//   apb      | in  | psel/penable  | paddr, pwdata, prdata (64-bit registers at 8*i)
//
// Each item passes through the event register and leaves through the
// directive register; one item per cycle is sustained while the directive
// is taken or the directive register is empty.
// Reset clears scheduler state, sets register defaults; first tick starts acquisition.
// A stalled directive holds the event register; the input takes a new item
// in the same cycle the directive is taken.
module radio_listen_window_scheduler (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  rlws_evt_if.sink                evt_i,
  rlws_dir_if.source              dir_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [rlws_pkg::AddrW-1:0] paddr,
  input  logic [rlws_pkg::DataW-1:0] pwdata,
  output logic [rlws_pkg::DataW-1:0] prdata,
  output logic                    pready
);
  import rlws_pkg::*;

  logic [LimitW-1:0]   acq_to_q, dwell_q, interval_q, duration_q;
  logic                exit_fix_q;
  logic [BandCntW-1:0] band_cnt_q;

  logic                stage_v_q;
  logic [CmdW-1:0]     stage_cmd_q;
  logic [TimeW-1:0]    stage_time_q;

  logic                out_v_q;
  phase_e              out_phase_q;
  logic                out_link_q, out_radio_q, out_bvalid_q;
  logic [BandW-1:0]    out_band_q;

  logic                started_q, started_d;
  phase_e              phase_q, phase_d;
  logic [TimeW-1:0]    acq_begin_q, acq_begin_d;
  logic [TimeW-1:0]    band_begin_q, band_begin_d;
  logic [TimeW-1:0]    listen_begin_q, listen_begin_d;
  logic [TimeW-1:0]    last_stop_q, last_stop_d;
  logic [BandW-1:0]    cur_band_q, cur_band_d;
  logic                fix_seen_q, fix_seen_d;
  logic                listen_want_q, listen_want_d;
  logic                serve_want_q, serve_want_d;
  logic [CountW-1:0]   count_q [MaxBands];
  logic [CountW-1:0]   count_d [MaxBands];

  logic                adv, fire, cfg_wr;
  reg_e                cfg_idx;
  logic [BandCntW-1:0] band_wr;
  logic [TimeW-1:0]    t;
  logic [TimeW-1:0]    acq_begin_eff, band_begin_eff;
  logic [BandW-1:0]    cur_band_eff, rot_band, pref_band;
  logic [BandCntW-1:0] band_inc;
  logic                fix_eff, serve_eff;
  logic                el_acq, el_band, el_int, el_dur;
  logic                found;
  logic [CountW-1:0]   best_cnt;
  logic                radio_d;

  assign adv   = !out_v_q || dir_o.ready;
  assign fire  = stage_v_q && adv;
  assign evt_i.ready = !stage_v_q || adv;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[AddrW-1:AddrW-RegIdxW]);
  assign band_wr = (pwdata[BandCntW-1:0] > BandCountMax) ? BandCountMax
                                                          : pwdata[BandCntW-1:0];

  always_comb begin
    case (cfg_idx)
      RegAcqTimeout: prdata = {{(DataW-LimitW){1'b0}}, acq_to_q};
      RegBandDwell:  prdata = {{(DataW-LimitW){1'b0}}, dwell_q};
      RegInterval:   prdata = {{(DataW-LimitW){1'b0}}, interval_q};
      RegDuration:   prdata = {{(DataW-LimitW){1'b0}}, duration_q};
      RegExitOnFix:  prdata = {{(DataW-1){1'b0}}, exit_fix_q};
      RegBandCount:  prdata = {{(DataW-BandCntW){1'b0}}, band_cnt_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acq_to_q   <= AcqTimeoutRst;
      dwell_q    <= BandDwellRst;
      interval_q <= IntervalRst;
      duration_q <= DurationRst;
      exit_fix_q <= 1'b1;
      band_cnt_q <= BandCountRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegAcqTimeout: acq_to_q   <= pwdata[LimitW-1:0];
        RegBandDwell:  dwell_q    <= pwdata[LimitW-1:0];
        RegInterval:   interval_q <= pwdata[LimitW-1:0];
        RegDuration:   duration_q <= pwdata[LimitW-1:0];
        RegExitOnFix:  exit_fix_q <= pwdata[0];
        RegBandCount:  band_cnt_q <= band_wr;
        default: ;
      endcase
    end
  end

  // event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else if (evt_i.ready) begin
      stage_v_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      stage_cmd_q  <= evt_i.command;
      stage_time_q <= evt_i.time_us;
    end
  end

  assign t              = stage_time_q;
  assign acq_begin_eff  = started_q ? acq_begin_q : t;
  assign band_begin_eff = started_q ? band_begin_q : t;
  assign cur_band_eff   = started_q ? cur_band_q : '0;
  assign fix_eff        = started_q && fix_seen_q;
  assign serve_eff      = started_q && serve_want_q;

  assign el_acq = elapsed(t, acq_begin_eff, acq_to_q);
  assign el_band = elapsed(t, band_begin_eff, dwell_q);
  assign el_int = elapsed(t, last_stop_q, interval_q);
  assign el_dur = elapsed(t, listen_begin_q, duration_q);

  assign band_inc = {{(BandCntW-BandW){1'b0}}, cur_band_eff} + BandCntW'(1);
  assign rot_band = (band_inc >= band_cnt_q) ? '0 : band_inc[BandW-1:0];

  always_comb begin
    found     = 1'b0;
    best_cnt  = '0;
    pref_band = cur_band_q;
    for (int i = 0; i < MaxBands; i++) begin
      if ((BandCntW'(i) < band_cnt_q) && (!found || count_q[i] > best_cnt)) begin
        found     = 1'b1;
        best_cnt  = count_q[i];
        pref_band = BandW'(i);
      end
    end
  end

  always_comb begin
    started_d      = started_q;
    phase_d        = phase_q;
    acq_begin_d    = acq_begin_q;
    band_begin_d   = band_begin_q;
    listen_begin_d = listen_begin_q;
    last_stop_d    = last_stop_q;
    cur_band_d     = cur_band_q;
    fix_seen_d     = fix_seen_q;
    listen_want_d  = listen_want_q;
    serve_want_d   = serve_want_q;
    count_d        = count_q;
    case (cmd_e'(stage_cmd_q))
      CmdTick: begin
        if (!started_q) begin
          started_d     = 1'b1;
          phase_d       = PhAcq;
          acq_begin_d   = t;
          band_begin_d  = t;
          cur_band_d    = '0;
          fix_seen_d    = 1'b0;
          listen_want_d = 1'b0;
          serve_want_d  = 1'b0;
        end
        case (phase_q)
          PhAcq: begin
            if (fix_eff || serve_eff || el_acq) begin
              phase_d       = PhSrv;
              last_stop_d   = t;
              listen_want_d = 1'b0;
              serve_want_d  = 1'b0;
            end else if (band_cnt_q != '0 && el_band) begin
              cur_band_d   = rot_band;
              band_begin_d = t;
            end
          end
          PhSrv: begin
            if (listen_want_q || el_int) begin
              phase_d        = PhLis;
              listen_begin_d = t;
              band_begin_d   = t;
              cur_band_d     = pref_band;
              listen_want_d  = 1'b0;
              serve_want_d   = 1'b0;
            end
          end
          PhLis: begin
            if (serve_want_q || el_dur) begin
              phase_d       = PhSrv;
              last_stop_d   = t;
              listen_want_d = 1'b0;
              serve_want_d  = 1'b0;
            end else if (band_cnt_q != '0 && el_band) begin
              cur_band_d   = rot_band;
              band_begin_d = t;
            end
          end
          default: ;
        endcase
      end
      CmdRadioFix: begin
        fix_seen_d = 1'b1;
        if (band_cnt_q != '0 && count_q[cur_band_q] != CountMax) begin
          count_d[cur_band_q] = count_q[cur_band_q] + CountW'(1);
        end
        if (phase_q == PhLis && exit_fix_q) begin
          phase_d       = PhSrv;
          last_stop_d   = t;
          listen_want_d = 1'b0;
          serve_want_d  = 1'b0;
        end
      end
      CmdBcastFix:  fix_seen_d    = 1'b1;
      CmdReqListen: listen_want_d = 1'b1;
      CmdReqServe:  serve_want_d  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q      <= 1'b0;
      phase_q        <= PhAcq;
      acq_begin_q    <= '0;
      band_begin_q   <= '0;
      listen_begin_q <= '0;
      last_stop_q    <= '0;
      cur_band_q     <= '0;
      fix_seen_q     <= 1'b0;
      listen_want_q  <= 1'b0;
      serve_want_q   <= 1'b0;
      for (int i = 0; i < MaxBands; i++) count_q[i] <= '0;
    end else if (cfg_wr && cfg_idx == RegBandCount) begin
      cur_band_q <= '0;
      for (int i = 0; i < MaxBands; i++) count_q[i] <= '0;
    end else if (fire) begin
      started_q      <= started_d;
      phase_q        <= phase_d;
      acq_begin_q    <= acq_begin_d;
      band_begin_q   <= band_begin_d;
      listen_begin_q <= listen_begin_d;
      last_stop_q    <= last_stop_d;
      cur_band_q     <= cur_band_d;
      fix_seen_q     <= fix_seen_d;
      listen_want_q  <= listen_want_d;
      serve_want_q   <= serve_want_d;
      count_q        <= count_d;
    end
  end

  // directive register
  assign radio_d = (phase_d != PhSrv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= stage_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_phase_q  <= phase_d;
      out_link_q   <= (phase_d == PhSrv);
      out_radio_q  <= radio_d;
      out_bvalid_q <= radio_d && (band_cnt_q != '0);
      out_band_q   <= (radio_d && band_cnt_q != '0) ? cur_band_d : '0;
    end
  end

  assign dir_o.valid           = out_v_q;
  assign dir_o.phase           = out_phase_q;
  assign dir_o.link_up         = out_link_q;
  assign dir_o.radio_listening = out_radio_q;
  assign dir_o.band_index      = out_band_q;
  assign dir_o.band_valid      = out_bvalid_q;

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_v_q)
    else $error("directive register missed an item");

  a_idle_before_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> phase_q == PhAcq)
    else $error("phase left acquiring before the first tick");

  a_band_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (band_cnt_q != '0) |->
      ({{(BandCntW-BandW){1'b0}}, cur_band_q} < band_cnt_q))
    else $error("current band outside rotation");

  a_stall_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !dir_o.ready) |=> $stable(out_phase_q) && $stable(out_band_q))
    else $error("stalled directive changed");

endmodule
